### design/tga_rle_pkg.sv
package tga_rle_pkg;

    // apb address width: three 32-bit registers at byte offsets 0, 4 and 8
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd2;

    localparam logic [15:0] IMAGE_WIDTH_RST     = 16'd1;
    localparam logic [15:0] IMAGE_HEIGHT_RST    = 16'd1;
    localparam logic [2:0]  BYTES_PER_PIXEL_RST = 3'd4;
    localparam logic [2:0]  BPP_WITH_ALPHA      = 3'd4;

    // packet header coding
    localparam logic [7:0] RAW_LIMIT = 8'd128;
    localparam logic [7:0] RUN_BIAS  = 8'd127;

    // pixel byte positions
    localparam logic [1:0] BYTE_BLUE  = 2'd0;
    localparam logic [1:0] BYTE_GREEN = 2'd1;
    localparam logic [1:0] BYTE_RED   = 2'd2;
    localparam logic [1:0] LAST_BGR   = 2'd2;
    localparam logic [1:0] LAST_BGRA  = 2'd3;

    // settings handed from the register file to the decode datapath
    typedef struct packed {
        logic [31:0] total_pixels;
        logic        four_bytes;
    } cfg_t;

endpackage

### design/tga_rle_regs.sv
module tga_rle_regs
    import tga_rle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [2:0]  bytes_per_pixel_reg;
    logic [31:0] total_pixels_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= IMAGE_WIDTH_RST;
            image_height_reg    <= IMAGE_HEIGHT_RST;
            bytes_per_pixel_reg <= BYTES_PER_PIXEL_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:     image_width_reg     <= pwdata[15:0];
                REG_IMAGE_HEIGHT:    image_height_reg    <= pwdata[15:0];
                REG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // pixel count registered so the multiplier stays off the decode path
    always_ff @(posedge aclk) begin
        total_pixels_reg <= 32'(image_width_reg) * 32'(image_height_reg);
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:     prdata = {16'd0, image_width_reg};
            REG_IMAGE_HEIGHT:    prdata = {16'd0, image_height_reg};
            REG_BYTES_PER_PIXEL: prdata = {29'd0, bytes_per_pixel_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.total_pixels = total_pixels_reg;
    assign cfg.four_bytes   = (bytes_per_pixel_reg == BPP_WITH_ALPHA);

endmodule

### design/tga_rle_pixel_decoder.sv
// tga_rle_pixel_decoder: run-length decoder for the pixel stream of a
// true-colour tga image.
// - input channel (s_valid/s_ready/s_data_byte): one compressed byte per
//   transaction, packet headers and pixel bytes alike, pixel bytes in b,g,r(,a)
// - result channel (m_valid/m_ready/m_*): one transaction per pixel on its last
//   byte; a run packet gives a single transaction with m_repeat_count set
// - apb port: image_width at 0x0, image_height at 0x4, bytes_per_pixel at 0x8;
//   write only while the decoder is idle
// - path: an accepted byte waits in the input register, is decoded from there,
//   and a finished pixel is loaded into the result register behind the m_ ports
// - throughput: one byte per cycle while the result register is free or taken,
//   set by the single decode stage between the input register and the result register
// - a stalled receiver holds the result register; one more byte can wait in
//   the input register, then s_ready drops until the result is taken
// - reset (aresetn low at a clock edge) empties both registers, restores the
//   register defaults and puts the decoder back to waiting for a packet header
module tga_rle_pixel_decoder
    import tga_rle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // compressed byte stream
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    // decoded pixels
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    output logic [7:0]            m_alpha,
    output logic [7:0]            m_repeat_count,
    output logic                  m_image_done,
    output logic                  m_overrun,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;

    tga_rle_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // decoder state
    logic        expect_header_reg, expect_header_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [7:0]  pixels_left_reg, pixels_left_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0] pixel_bytes_reg, pixel_bytes_next;
    logic [31:0] pixels_done_reg, pixels_done_next;

    // result register
    logic        out_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg, count_reg;
    logic        done_reg, overrun_reg;

    // decode stage
    logic        decode_en;
    logic        emit;
    logic [7:0]  b;
    logic [1:0]  last_idx;
    logic [23:0] pixel_upd;
    logic [32:0] rem_ext;
    logic        rem_zero;
    logic [31:0] remaining;
    logic [7:0]  n_raw;
    logic        rem_fits;
    logic [7:0]  n_pix;
    logic [7:0]  left_after;
    logic        done_now;
    logic        overrun_now;

    // the decode stage fires when a byte is waiting and the result slot can take
    // whatever it produces
    assign decode_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || decode_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (decode_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    assign b        = in_byte_reg;
    assign last_idx = cfg.four_bytes ? LAST_BGRA : LAST_BGR;

    // slot the byte into the stored pixel; the alpha byte is not stored
    always_comb begin
        pixel_upd = pixel_bytes_reg;
        case (byte_in_pixel_reg)
            BYTE_BLUE:  pixel_upd[7:0]   = b;
            BYTE_GREEN: pixel_upd[15:8]  = b;
            BYTE_RED:   pixel_upd[23:16] = b;
            default:    ;
        endcase
    end

    // pixels still owed to the image; a borrow means the count is already full
    assign rem_ext   = {1'b0, cfg.total_pixels} - {1'b0, pixels_done_reg};
    assign rem_zero  = rem_ext[32] || (rem_ext[31:0] == 32'd0);
    assign remaining = rem_ext[32] ? 32'd0 : rem_ext[31:0];

    // pixels this result covers, clipped to what is left of the image
    assign n_raw = (packet_is_run_reg && (pixels_left_reg != 8'd0)) ? pixels_left_reg
                                                                    : 8'd1;
    assign rem_fits    = (remaining[31:8] == 24'd0) && (remaining[7:0] <= n_raw);
    assign n_pix       = rem_fits ? remaining[7:0] : n_raw;
    assign left_after  = (pixels_left_reg > n_pix) ? (pixels_left_reg - n_pix) : 8'd0;
    // clipping to the remaining count is exactly what completes the image
    assign done_now    = rem_fits;
    assign overrun_now = rem_fits && (pixels_left_reg > n_pix);

    always_comb begin
        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        pixels_left_next   = pixels_left_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        pixel_bytes_next   = pixel_bytes_reg;
        pixels_done_next   = pixels_done_reg;
        emit               = 1'b0;

        if (expect_header_reg) begin
            // a header after a finished image starts the next one
            if (rem_zero) begin
                pixels_done_next = 32'd0;
            end
            if (b < RAW_LIMIT) begin
                packet_is_run_next = 1'b0;
                pixels_left_next   = b + 8'd1;
            end else begin
                packet_is_run_next = 1'b1;
                pixels_left_next   = b - RUN_BIAS;
            end
            expect_header_next = 1'b0;
            byte_in_pixel_next = BYTE_BLUE;
            pixel_bytes_next   = '0;
        end else begin
            pixel_bytes_next = pixel_upd;
            if (byte_in_pixel_reg < last_idx) begin
                byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
            end else begin
                byte_in_pixel_next = BYTE_BLUE;
                if (rem_zero) begin
                    // image already complete: drop the pixel
                    if (packet_is_run_reg || (pixels_left_reg <= 8'd1)) begin
                        pixels_left_next   = 8'd0;
                        expect_header_next = 1'b1;
                    end else begin
                        pixels_left_next = pixels_left_reg - 8'd1;
                    end
                end else begin
                    emit             = 1'b1;
                    pixels_done_next = pixels_done_reg + 32'(n_pix);
                    if (packet_is_run_reg) begin
                        pixels_left_next   = 8'd0;
                        expect_header_next = 1'b1;
                    end else begin
                        pixels_left_next = left_after;
                        if (left_after == 8'd0) begin
                            expect_header_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            pixels_left_reg   <= 8'd0;
            byte_in_pixel_reg <= BYTE_BLUE;
            pixel_bytes_reg   <= '0;
            pixels_done_reg   <= 32'd0;
        end else if (decode_en) begin
            expect_header_reg <= expect_header_next;
            packet_is_run_reg <= packet_is_run_next;
            pixels_left_reg   <= pixels_left_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            pixel_bytes_reg   <= pixel_bytes_next;
            pixels_done_reg   <= pixels_done_next;
        end
    end

    // result register: loads on a new pixel, empties when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (decode_en && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (decode_en && emit) begin
            red_reg     <= pixel_upd[23:16];
            green_reg   <= pixel_upd[15:8];
            blue_reg    <= pixel_upd[7:0];
            alpha_reg   <= cfg.four_bytes ? b : 8'd0;
            count_reg   <= n_pix;
            done_reg    <= done_now;
            overrun_reg <= overrun_now;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_alpha        = alpha_reg;
    assign m_repeat_count = count_reg;
    assign m_image_done   = done_reg;
    assign m_overrun      = overrun_reg;

endmodule

### design/tga_rle_checker.sv
module tga_rle_checker
    import tga_rle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_red,
    input  logic [7:0] m_green,
    input  logic [7:0] m_blue,
    input  logic [7:0] m_alpha,
    input  logic [7:0] m_repeat_count,
    input  logic       m_image_done,
    input  logic       m_overrun
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_alpha) && $stable(m_repeat_count)
            && $stable(m_image_done) && $stable(m_overrun))
        else $error("result changed while stalled");

    // every result covers between one and a full run of pixels
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_repeat_count != 8'd0) && (m_repeat_count <= RAW_LIMIT))
        else $error("repeat count out of range");

    // clipping only happens on the result that ends the image
    a_overrun_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overrun |-> m_image_done)
        else $error("overrun without image end");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_red          (m_red),
    .m_green        (m_green),
    .m_blue         (m_blue),
    .m_alpha        (m_alpha),
    .m_repeat_count (m_repeat_count),
    .m_image_done   (m_image_done),
    .m_overrun      (m_overrun)
);

### tb/sv/tga_rle_result_checker.sv
`timescale 1ns / 100ps

module tga_rle_result_checker
    import tga_rle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [7:0]            m_red,
    input  logic [7:0]            m_green,
    input  logic [7:0]            m_blue,
    input  logic [7:0]            m_alpha,
    input  logic [7:0]            m_repeat_count,
    input  logic                  m_image_done,
    input  logic                  m_overrun,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int unsigned           mismatch_count,
    output int unsigned           results_pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_done;
        logic       overrun;
    } pixel_result_t;

    pixel_result_t expected_pixels [$];
    pixel_result_t oldest_pixel;

    // settings as seen on the register port
    logic [15:0] cfg_width;
    logic [15:0] cfg_height;
    logic [2:0]  cfg_bpp;

    // decoder state
    logic        awaiting_header;
    logic        in_run;
    logic [7:0]  pixels_in_packet;
    logic [1:0]  byte_idx;
    logic [23:0] colour_bytes;
    logic [31:0] image_pixel_count;

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // one compressed byte; queues a decoded pixel when the byte finishes one
    task automatic decode_byte(input logic [7:0] value);
        logic [31:0]   total;
        logic [31:0]   remaining;
        logic [31:0]   covered;
        logic [31:0]   left_after;
        logic          with_alpha;
        logic [1:0]    last_idx;
        pixel_result_t pixel;
        total      = 32'(cfg_width) * 32'(cfg_height);
        with_alpha = (cfg_bpp == BPP_WITH_ALPHA);
        last_idx   = with_alpha ? LAST_BGRA : LAST_BGR;
        if (awaiting_header) begin
            if (image_pixel_count >= total) image_pixel_count = '0;
            if (value < RAW_LIMIT) begin
                in_run           = 1'b0;
                pixels_in_packet = value + 8'd1;
            end else begin
                in_run           = 1'b1;
                pixels_in_packet = value - RUN_BIAS;
            end
            awaiting_header = 1'b0;
            byte_idx        = BYTE_BLUE;
            colour_bytes    = '0;
            return;
        end
        if (byte_idx < 2'd3) colour_bytes[8*byte_idx +: 8] = value;
        if (byte_idx < last_idx) begin
            byte_idx = byte_idx + 2'd1;
            return;
        end
        byte_idx  = BYTE_BLUE;
        remaining = (total > image_pixel_count) ? total - image_pixel_count : '0;
        if (remaining == 0) begin
            // image already complete: the pixel is swallowed
            if (in_run || pixels_in_packet <= 8'd1) begin
                pixels_in_packet = '0;
                awaiting_header  = 1'b1;
            end else begin
                pixels_in_packet = pixels_in_packet - 8'd1;
            end
            return;
        end
        covered = in_run ? 32'(pixels_in_packet) : 32'd1;
        if (covered == 0) covered = 32'd1;
        if (covered > remaining) covered = remaining;
        left_after = (32'(pixels_in_packet) > covered) ?
                     32'(pixels_in_packet) - covered : '0;
        image_pixel_count = image_pixel_count + covered;
        pixel.image_done  = (image_pixel_count == total);
        pixel.overrun     = pixel.image_done && (left_after != 0);
        if (in_run) begin
            pixels_in_packet = '0;
            awaiting_header  = 1'b1;
        end else begin
            pixels_in_packet = left_after[7:0];
            if (left_after == 0) awaiting_header = 1'b1;
        end
        pixel.red          = colour_bytes[23:16];
        pixel.green        = colour_bytes[15:8];
        pixel.blue         = colour_bytes[7:0];
        pixel.alpha        = with_alpha ? value : 8'd0;
        pixel.repeat_count = covered[7:0];
        expected_pixels.push_back(pixel);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width         = IMAGE_WIDTH_RST;
            cfg_height        = IMAGE_HEIGHT_RST;
            cfg_bpp           = BYTES_PER_PIXEL_RST;
            awaiting_header   = 1'b1;
            in_run            = 1'b0;
            pixels_in_packet  = '0;
            byte_idx          = BYTE_BLUE;
            colour_bytes      = '0;
            image_pixel_count = '0;
            expected_pixels.delete();
        end else begin
            // results first, so a byte taken at this edge cannot match a result leaving now
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: red %0d green %0d blue %0d alpha %0d count %0d",
                           m_red, m_green, m_blue, m_alpha, m_repeat_count);
                    mismatch_count++;
                end else begin
                    oldest_pixel = expected_pixels.pop_front();
                    check_field("red", oldest_pixel.red, m_red);
                    check_field("green", oldest_pixel.green, m_green);
                    check_field("blue", oldest_pixel.blue, m_blue);
                    check_field("alpha", oldest_pixel.alpha, m_alpha);
                    check_field("repeat_count", oldest_pixel.repeat_count, m_repeat_count);
                    check_field("image_done", 8'(oldest_pixel.image_done), 8'(m_image_done));
                    check_field("overrun", 8'(oldest_pixel.overrun), 8'(m_overrun));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_IMAGE_WIDTH: begin
                        cfg_width = pwdata[15:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        cfg_height = pwdata[15:0];
                    end
                    REG_BYTES_PER_PIXEL: begin
                        cfg_bpp = pwdata[2:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) decode_byte(s_data_byte);
        end
        results_pending = expected_pixels.size();
    end

endmodule

### tb/sv/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 100ps

module tb_tga_rle_pixel_decoder
    import tga_rle_pkg::*;
();

    localparam int unsigned PHASES = 13;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // byte stream into the decoder
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'd0;

    // decoded pixels out of it
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;
    logic [7:0] m_alpha;
    logic [7:0] m_repeat_count;
    logic       m_image_done;
    logic       m_overrun;

    // register port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned mismatch_count;
    int unsigned results_pending;

    // stimulus bookkeeping
    logic [2:0]  cur_bpp         = BYTES_PER_PIXEL_RST;
    int unsigned phase_bytes     = 0;
    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;
    int unsigned stall_left      = 0;
    logic [7:0]  opening_bytes [$];

    // bytes per pixel for each random phase: 3 and 4 mostly, every code but 4 decodes as 3
    logic [2:0] phase_bpp [PHASES] = '{3'd3, 3'd4, 3'd7, 3'd4, 3'd0, 3'd3, 3'd4,
                                       3'd5, 3'd1, 3'd4, 3'd2, 3'd6, 3'd4};

    always #1 aclk = ~aclk;

    tga_rle_pixel_decoder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_repeat_count (m_repeat_count),
        .m_image_done   (m_image_done),
        .m_overrun      (m_overrun),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    tga_rle_result_checker i_result_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_alpha         (m_alpha),
        .m_repeat_count  (m_repeat_count),
        .m_image_done    (m_image_done),
        .m_overrun       (m_overrun),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // idle stretch length: mostly from the shortest range, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 3);
        else if (pick < 95) return $urandom_range(4, 10);
        else return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure; steady stretches flip on and off now and then
    always @(negedge aclk) begin
        if ($urandom_range(0, 149) == 0) receiver_steady = !receiver_steady;
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!receiver_steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    // one byte transaction; entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] value);
        int unsigned idle;
        idle = (!sender_steady && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        phase_bytes++;
    endtask

    // stop sending and hold off until every pixel is out and the pipe is quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        wait (results_pending == 0);
        repeat (4) @(negedge aclk);
    endtask

    // apb write: setup cycle, access cycle, then the bus is idle before the task returns;
    // upper data bits are junk on purpose
    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [15:0] width, input logic [15:0] height,
                                  input logic [2:0] bpp);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_BYTES_PER_PIXEL, {13'($urandom), bpp});
        cur_bpp = bpp;
    endtask

    // well-formed packet: header then every pixel byte, short packets favoured
    task automatic send_packet();
        logic [7:0]  header;
        int unsigned pick;
        int unsigned pixels;
        int unsigned per_pixel;
        pick = $urandom_range(0, 99);
        if (pick < 45) header = 8'($urandom_range(0, 3));
        else if (pick < 88) header = 8'($urandom_range(128, 135));
        else if (pick < 97) header = 8'($urandom_range(136, 255));
        else header = 8'($urandom_range(4, 31));
        per_pixel = (cur_bpp == BPP_WITH_ALPHA) ? 4 : 3;
        pixels    = (header < RAW_LIMIT) ? header + 1 : 1;
        send_byte(header);
        repeat (pixels * per_pixel) send_byte(8'($urandom));
    endtask

    initial begin
        int unsigned phase;
        int unsigned budget;
        logic [15:0] width;
        logic [15:0] height;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: a 3x1 image with alpha
        // two raw pixels with extreme bytes, then a 128-long run clipped at the image end,
        // then a run of one that opens the next image, then a raw pixel left half done
        sender_steady = ($urandom_range(0, 1) == 0);
        apply_settings(16'd3, 16'd1, BPP_WITH_ALPHA);
        opening_bytes = '{8'h01, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'hAA, 8'h55,
                          8'hFF, 8'h12, 8'h34, 8'h56, 8'h78,
                          8'h80, 8'h01, 8'h02, 8'h03, 8'h04,
                          8'h00, 8'h9A, 8'hBC};
        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
        drain_results();

        // drop to three bytes per pixel in mid-pixel: the next byte closes the pixel
        write_reg(REG_BYTES_PER_PIXEL, {13'($urandom), 3'd3});
        cur_bpp = 3'd3;
        send_byte(8'hDE);
        drain_results();

        // zero-width image: the run is swallowed without a result
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        send_byte(8'h81);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        drain_results();

        // random phases: mostly tiny images so completion, clipping and restart recur,
        // plus the largest image and the empty ones
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                2: begin
                    width  = 16'hFFFF;
                    height = 16'hFFFF;
                end
                5: begin
                    width  = 16'd0;
                    height = 16'($urandom_range(1, 4));
                end
                8: begin
                    width  = 16'($urandom_range(1, 6));
                    height = 16'd0;
                end
                default: begin
                    width  = 16'($urandom_range(1, 6));
                    height = 16'($urandom_range(1, 4));
                end
            endcase
            apply_settings(width, height, phase_bpp[phase]);
            budget        = (width == 0 || height == 0) ? 25 : 70;
            sender_steady = ($urandom_range(0, 3) == 0);
            phase_bytes   = 0;
            while (phase_bytes < budget) begin
                if ($urandom_range(0, 9) < 8) send_packet();
                else repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            // the sender waits here for every outstanding pixel before the next settings
            drain_results();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
design/tga_rle_pkg.sv
design/tga_rle_regs.sv
design/tga_rle_pixel_decoder.sv
design/tga_rle_checker.sv
tb/sv/tga_rle_result_checker.sv
tb/sv/tb_tga_rle_pixel_decoder.sv
